@@ rtl/core/lpgt_pkg.sv @@
// Shared types and constants for the lidar point gate and transform unit.
package lpgt_pkg;

  // Configuration register file
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_X_LOW    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_X_HIGH   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_Y_LOW    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_Y_HIGH   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BUBBLE_RADIUS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_RADIUS = 4'd7;

  // Signed window limits are held as raw bits; users apply $signed
  typedef struct packed {
    logic [15:0] min_range;
    logic [15:0] max_range;
    logic [15:0] field_x_low;
    logic [15:0] field_x_high;
    logic [15:0] field_y_low;
    logic [15:0] field_y_high;
    logic [15:0] bubble_radius;
    logic [15:0] forward_radius;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_range:      16'd100,
    max_range:      16'd4000,
    field_x_low:    16'd100,
    field_x_high:   16'd2900,
    field_y_low:    16'd100,
    field_y_high:   16'd1900,
    bubble_radius:  16'd300,
    forward_radius: 16'd600
  };

  // Classified point, as it travels from the front end to the back end
  typedef struct packed {
    logic [15:0] range_mm;
    logic [15:0] theta;
    logic [15:0] robot_x;
    logic [15:0] robot_y;
    logic        range_ok;
    logic        bubble_hit;
    logic        fwd_hit;
    logic        scan_end;
  } item_t;

  // Decoupling queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Binary angle and sine polynomial constants
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [16:0] SIN_A        = 17'd102944;
  localparam logic [15:0] SIN_B        = 16'd42047;
  localparam logic [12:0] SIN_C        = 13'd4639;
  localparam logic [14:0] U_FULL       = 15'd16384;

  // Score increments
  localparam logic [1:0] SCORE_BUBBLE  = 2'd2;
  localparam logic [1:0] SCORE_FORWARD = 2'd1;
  localparam logic [1:0] SCORE_NONE    = 2'd0;

endpackage

@@ rtl/core/lpgt_ifs.sv @@
// Valid/ready channel interfaces for lidar points and gated results.
interface lpgt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] lidar_angle;
  logic        [15:0] range_mm;
  logic signed [15:0] robot_x;
  logic signed [15:0] robot_y;
  logic signed [15:0] robot_heading;
  logic               scan_end;

  modport source (
    output valid, lidar_angle, range_mm, robot_x, robot_y, robot_heading, scan_end,
    input  ready
  );
  modport sink (
    input  valid, lidar_angle, range_mm, robot_x, robot_y, robot_heading, scan_end,
    output ready
  );
endinterface

interface lpgt_out_if;
  logic               valid;
  logic               ready;
  logic               point_kept;
  logic signed [15:0] field_x;
  logic signed [15:0] field_y;
  logic               scan_done;
  logic        [15:0] guard_score;

  modport source (
    output valid, point_kept, field_x, field_y, scan_done, guard_score,
    input  ready
  );
  modport sink (
    input  valid, point_kept, field_x, field_y, scan_done, guard_score,
    output ready
  );
endinterface

@@ rtl/core/lpgt_front.sv @@
// Front end: accepts points, applies the range gate and classifies the scoring zone.
module lpgt_front #(
  parameter int unsigned BUBBLE_HALF_ANGLE  = 8192,
  parameter int unsigned FORWARD_HALF_ANGLE = 4096
) (
  lpgt_in_if.sink         in_chan,
  input  lpgt_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output lpgt_pkg::item_t q_data
);

  localparam logic signed [16:0] BUB_LIM = 17'(BUBBLE_HALF_ANGLE);
  localparam logic signed [16:0] FWD_LIM = 17'(FORWARD_HALF_ANGLE);

  logic signed [16:0] ang_ext;
  logic               bub_cone;
  logic               fwd_cone;

  // Take a transaction whenever the queue has room
  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  // Angular zones on the sensor bearing
  assign ang_ext  = {in_chan.lidar_angle[15], in_chan.lidar_angle};
  assign bub_cone = (ang_ext >= -BUB_LIM) && (ang_ext <= BUB_LIM);
  assign fwd_cone = (ang_ext >= -FWD_LIM) && (ang_ext <= FWD_LIM);

  // Classification
  always_comb begin
    q_data.range_mm   = in_chan.range_mm;
    q_data.theta      = in_chan.robot_heading - in_chan.lidar_angle;
    q_data.robot_x    = in_chan.robot_x;
    q_data.robot_y    = in_chan.robot_y;
    q_data.range_ok   = (in_chan.range_mm > cfg.min_range) &&
                        (in_chan.range_mm < cfg.max_range);
    q_data.bubble_hit = bub_cone && (in_chan.range_mm <= cfg.bubble_radius);
    q_data.fwd_hit    = fwd_cone && (in_chan.range_mm <= cfg.forward_radius);
    q_data.scan_end   = in_chan.scan_end;
  end

endmodule

@@ rtl/core/lpgt_queue.sv @@
// Short FIFO between the front end and the transform pipeline.
module lpgt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lpgt_pkg::item_t push_data,
  input  logic            pop,
  output lpgt_pkg::item_t head,
  output logic            full,
  output logic            empty
);

  lpgt_pkg::item_t                  slot_r [lpgt_pkg::QUEUE_DEPTH];
  logic [lpgt_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [lpgt_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [lpgt_pkg::QCNT_W-1:0]      count_r;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (count_r == lpgt_pkg::QCNT_W'(lpgt_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ rtl/core/lpgt_trig.sv @@
// Four-stage polynomial sine of a 16-bit binary angle, sign and magnitude out.
module lpgt_trig #(
  parameter int unsigned TRIG_FRAC_BITS = 15
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [15:0]               angle,
  output logic [TRIG_FRAC_BITS-1:0] mag,
  output logic                      neg
);

  localparam int unsigned SH  = 16 - TRIG_FRAC_BITS;
  localparam logic [17:0] RND = 18'(1 << (SH - 1));
  localparam logic [17:0] LIM = 18'((1 << TRIG_FRAC_BITS) - 1);
  localparam logic [14:0] U_FULL_C = lpgt_pkg::U_FULL;

  logic [14:0] u_in;
  logic [29:0] sq;
  logic [27:0] p_c;
  logic [30:0] p_t1;
  logic [31:0] p_t2;
  logic [17:0] r_rnd;

  logic [14:0] u1_r, u2_r, u3_r;
  logic [14:0] z2_1_r, z2_2_r;
  logic [15:0] t1_2_r;
  logic [16:0] t2_3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [TRIG_FRAC_BITS-1:0] mag4_r;
  logic        neg4_r;

  // Fold into the first quadrant and square
  assign u_in  = angle[14] ? (U_FULL_C - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign sq    = u_in * u_in;

  // Horner steps
  assign p_c   = lpgt_pkg::SIN_C * z2_1_r;
  assign p_t1  = t1_2_r * z2_2_r;
  assign p_t2  = t2_3_r * u3_r;

  // Round Q16 magnitude to the trig fraction width
  assign r_rnd = (18'(p_t2 >> 14) + RND) >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r   <= u_in;
      z2_1_r <= sq[28:14];
      neg1_r <= angle[15];

      u2_r   <= u1_r;
      z2_2_r <= z2_1_r;
      t1_2_r <= lpgt_pkg::SIN_B - 16'(p_c >> 14);
      neg2_r <= neg1_r;

      u3_r   <= u2_r;
      t2_3_r <= lpgt_pkg::SIN_A - 17'(p_t1 >> 14);
      neg3_r <= neg2_r;

      mag4_r <= (r_rnd > LIM) ? LIM[TRIG_FRAC_BITS-1:0] : r_rnd[TRIG_FRAC_BITS-1:0];
      neg4_r <= neg3_r;
    end
  end

  assign mag = mag4_r;
  assign neg = neg4_r;

endmodule

@@ rtl/core/lpgt_back.sv @@
// Back end: rotation, offset, field gate and protection score, with the result register.
module lpgt_back #(
  parameter int unsigned TRIG_FRAC_BITS = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lpgt_pkg::cfg_t  cfg,
  input  lpgt_pkg::item_t head,
  input  logic            q_empty,
  output logic            q_pop,
  lpgt_out_if.source      out_chan
);

  localparam int unsigned MAG_W  = TRIG_FRAC_BITS;
  localparam int unsigned PR_W   = 16 + MAG_W;
  localparam logic [PR_W:0] P_RND = (PR_W + 1)'(1 << (MAG_W - 1));
  localparam int unsigned NSTG   = 6;

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] res;
    if (v > 18'sd32767)       res = 16'h7FFF;
    else if (v < -18'sd32768) res = 16'h8000;
    else                      res = v[15:0];
    return res;
  endfunction

  logic                 adv;
  logic [15:0]          ang_cos;
  logic [MAG_W-1:0]     mag_c, mag_s;
  logic                 neg_c, neg_s;
  logic [PR_W-1:0]      pr_x, pr_y;
  logic [PR_W:0]        rs_x, rs_y;
  logic signed [17:0]   bx, by, vx, vy;
  logic                 in_win;
  logic                 kept;
  logic [1:0]           inc;
  logic [16:0]          sum;
  logic [15:0]          score;

  lpgt_pkg::item_t      meta_r [NSTG];
  logic [NSTG-1:0]      vld_r;
  logic [15:0]          qx5_r, qy5_r;
  logic                 nx5_r, ny5_r;
  logic [15:0]          fx6_r, fy6_r;
  logic [15:0]          acc_r;
  logic                 out_valid_r;
  logic                 out_kept_r;
  logic [15:0]          out_fx_r, out_fy_r;
  logic                 out_done_r;
  logic [15:0]          out_score_r;

  // Whole pipeline advances unless the result register is held
  assign adv     = !out_valid_r || out_chan.ready;
  assign q_pop   = adv && !q_empty;
  assign ang_cos = head.theta + lpgt_pkg::QUARTER_TURN;

  lpgt_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos (
    .clk(clk), .en(adv), .angle(ang_cos), .mag(mag_c), .neg(neg_c)
  );
  lpgt_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin (
    .clk(clk), .en(adv), .angle(head.theta), .mag(mag_s), .neg(neg_s)
  );

  // Stage 5: range times trig, rounded to mm
  assign pr_x = meta_r[3].range_mm * mag_c;
  assign pr_y = meta_r[3].range_mm * mag_s;
  assign rs_x = {1'b0, pr_x} + P_RND;
  assign rs_y = {1'b0, pr_y} + P_RND;

  // Stage 6: signed offset by robot position and saturate
  assign bx = {{2{meta_r[4].robot_x[15]}}, meta_r[4].robot_x};
  assign by = {{2{meta_r[4].robot_y[15]}}, meta_r[4].robot_y};
  assign vx = nx5_r ? (bx - $signed({2'b00, qx5_r})) : (bx + $signed({2'b00, qx5_r}));
  assign vy = ny5_r ? (by - $signed({2'b00, qy5_r})) : (by + $signed({2'b00, qy5_r}));

  // Stage 7: field window and score
  assign in_win = !($signed(fx6_r) > $signed(cfg.field_x_high) ||
                    $signed(fx6_r) < $signed(cfg.field_x_low)  ||
                    $signed(fy6_r) > $signed(cfg.field_y_high) ||
                    $signed(fy6_r) < $signed(cfg.field_y_low));
  assign kept   = meta_r[5].range_ok && in_win;

  always_comb begin
    if (!kept)                    inc = lpgt_pkg::SCORE_NONE;
    else if (meta_r[5].bubble_hit) inc = lpgt_pkg::SCORE_BUBBLE;
    else if (meta_r[5].fwd_hit)    inc = lpgt_pkg::SCORE_FORWARD;
    else                          inc = lpgt_pkg::SCORE_NONE;
  end

  assign sum   = {1'b0, acc_r} + {15'd0, inc};
  assign score = sum[16] ? 16'hFFFF : sum[15:0];

  // Control: stage valids, result valid, score accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-2:0], q_pop};
      out_valid_r <= vld_r[NSTG-1];
      if (vld_r[NSTG-1]) acc_r <= meta_r[5].scan_end ? 16'd0 : score;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= head;
      for (int k = 1; k < NSTG; k++) meta_r[k] <= meta_r[k-1];
      qx5_r       <= rs_x[MAG_W +: 16];
      qy5_r       <= rs_y[MAG_W +: 16];
      nx5_r       <= neg_c;
      ny5_r       <= neg_s;
      fx6_r       <= meta_r[4].range_ok ? sat16(vx) : 16'd0;
      fy6_r       <= meta_r[4].range_ok ? sat16(vy) : 16'd0;
      out_kept_r  <= kept;
      out_fx_r    <= fx6_r;
      out_fy_r    <= fy6_r;
      out_done_r  <= meta_r[5].scan_end;
      out_score_r <= score;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.point_kept  = out_kept_r;
  assign out_chan.field_x     = out_fx_r;
  assign out_chan.field_y     = out_fy_r;
  assign out_chan.scan_done   = out_done_r;
  assign out_chan.guard_score = out_score_r;

endmodule

@@ rtl/core/lidar_point_gate_transform_unit.sv @@
// Top level of the lidar point gate and transform unit with its register file.
//
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        lidar_angle, range_mm, robot_x/y, robot_heading, scan_end
//  out_chan  out  valid/ready        point_kept, field_x, field_y, scan_done, guard_score
//  cfg_*     in   cfg_wr_en only     cfg_index (8 registers), cfg_wdata
//
// One point per cycle sustained while results are taken; one result for every point, in order.
// Each point passes the queue, the sine polynomial multiplier chain (four
// stages), then projection, offset and gate into the result register.
// Reset loads register defaults, clears the score and empties the 4-entry queue.
// A held result freezes the back end; the input stalls only when the queue fills.
module lidar_point_gate_transform_unit #(
  parameter int unsigned BUBBLE_HALF_ANGLE  = 8192,
  parameter int unsigned FORWARD_HALF_ANGLE = 4096,
  parameter int unsigned TRIG_FRAC_BITS     = 15
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lpgt_in_if.sink                         in_chan,
  lpgt_out_if.source                      out_chan,
  input  logic                            cfg_wr_en,
  input  logic [lpgt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpgt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lpgt_pkg::cfg_t  cfg_r;
  lpgt_pkg::item_t push_data;
  lpgt_pkg::item_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  // Register file; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lpgt_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lpgt_pkg::REG_MIN_RANGE:      cfg_r.min_range      <= cfg_wdata;
        lpgt_pkg::REG_MAX_RANGE:      cfg_r.max_range      <= cfg_wdata;
        lpgt_pkg::REG_FIELD_X_LOW:    cfg_r.field_x_low    <= cfg_wdata;
        lpgt_pkg::REG_FIELD_X_HIGH:   cfg_r.field_x_high   <= cfg_wdata;
        lpgt_pkg::REG_FIELD_Y_LOW:    cfg_r.field_y_low    <= cfg_wdata;
        lpgt_pkg::REG_FIELD_Y_HIGH:   cfg_r.field_y_high   <= cfg_wdata;
        lpgt_pkg::REG_BUBBLE_RADIUS:  cfg_r.bubble_radius  <= cfg_wdata;
        lpgt_pkg::REG_FORWARD_RADIUS: cfg_r.forward_radius <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lpgt_front #(
    .BUBBLE_HALF_ANGLE (BUBBLE_HALF_ANGLE),
    .FORWARD_HALF_ANGLE(FORWARD_HALF_ANGLE)
  ) u_front (
    .in_chan(in_chan),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (push),
    .q_data (push_data)
  );

  lpgt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  lpgt_back #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (pop),
    .out_chan(out_chan)
  );

endmodule
